// ===== rtl/core/swsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// swsfr_pkg
// Shared types and constants for the sliding-window sender with fast
// retransmit: beat formats, command kinds, event codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package swsfr_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SEQ_W        = 32;
    localparam int LIMIT_W      = 4;
    localparam int OUT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W        = (LIMIT_W > OUT_W) ? LIMIT_W : OUT_W;
    localparam int DUP_W        = 2;
    localparam logic [DUP_W-1:0] DUP_THRESHOLD = 2'd3;
    localparam logic [SEQ_W-1:0] SEQ_LAST      = {SEQ_W{1'b1}};

    localparam logic [LIMIT_W-1:0] WINDOW_LIMIT_RESET = 4'd8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register map
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_INITIAL_SEQ  = 1'b0;
    localparam logic REG_WINDOW_LIMIT = 1'b1;

    // input actions
    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // events
    localparam logic [2:0] EV_TX     = 3'd0;
    localparam logic [2:0] EV_REFUSE = 3'd1;
    localparam logic [2:0] EV_STOP   = 3'd2;
    localparam logic [2:0] EV_RETX   = 3'd3;
    localparam logic [2:0] EV_REJECT = 3'd4;
    localparam logic [2:0] EV_NONE   = 3'd5;

    // classified commands
    localparam logic [2:0] CMD_SEND    = 3'd0;
    localparam logic [2:0] CMD_ACK     = 3'd1;
    localparam logic [2:0] CMD_ACK_BAD = 3'd2;
    localparam logic [2:0] CMD_TIMEOUT = 3'd3;
    localparam logic [2:0] CMD_NOP     = 3'd4;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_checksum_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] ack_seq;
    } t_cmd;

    typedef struct packed {
        logic                  init_we;
        logic                  limit_we;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [SEQ_W-1:0]   initial_seq;
        logic [LIMIT_W-1:0] window_limit;
    } t_cfg_view;

endpackage

`default_nettype wire

// ===== rtl/core/swsfr_front.sv =====
// ----------------------------------------------------------------------------
// swsfr_front
// Accepts input beats, classifies them into commands and buffers them in a
// short queue so the back end can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module swsfr_front
    import swsfr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    t_cmd              w_cmd;
    logic              w_push, w_pop;

    // classify by action; checksum failures are settled here
    always_comb begin
        w_cmd.ack_seq = i_in_data.ack_seq;
        case (i_in_data.action)
            ACT_SEND:    w_cmd.kind = CMD_SEND;
            ACT_ACK:     w_cmd.kind = i_in_data.ack_checksum_ok ? CMD_ACK : CMD_ACK_BAD;
            ACT_TIMEOUT: w_cmd.kind = CMD_TIMEOUT;
            default:     w_cmd.kind = CMD_NOP;
        endcase
    end

    assign o_in_ready  = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count past depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue pop lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/swsfr_back.sv =====
// ----------------------------------------------------------------------------
// swsfr_back
// Carries out queued commands against the window state and emits events,
// one per cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module swsfr_back
    import swsfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cmd_valid,
    output logic         o_cmd_ready,
    input  wire t_cmd    i_cmd,
    input  wire t_cfg_wr i_cfg_wr,
    output t_cfg_view    o_cfg_view,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_out_item    o_out_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SLIDE = 1'b1;

    logic               r_state,        n_state;
    logic [SEQ_W-1:0]   r_initial_seq,  n_initial_seq;
    logic [LIMIT_W-1:0] r_window_limit, n_window_limit;
    logic [SEQ_W-1:0]   r_oldest_seq,   n_oldest_seq;
    logic [SEQ_W-1:0]   r_next_seq,     n_next_seq;
    logic [OUT_W-1:0]   r_outstanding,  n_outstanding;
    logic [DUP_W-1:0]   r_dup_acks,     n_dup_acks;
    logic [SEQ_W-1:0]   r_ack,          n_ack;
    logic               r_out_valid,    n_out_valid;
    t_out_item          r_out_item;

    logic             w_out_free;
    logic             w_emit;
    t_out_item        w_emit_item;
    logic             w_full;
    logic             w_ack_ge;
    logic             w_ack_dup;
    logic [SEQ_W-1:0] w_slide_ack;
    logic             w_stop_last;
    logic [DUP_W-1:0] w_dup_inc;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_cmd_ready = (r_state == ST_IDLE) && w_out_free;

    assign w_full = (CMP_W'(r_outstanding) >= CMP_W'(r_window_limit))
                 || (r_outstanding >= OUT_W'(WINDOW_DEPTH))
                 || (r_next_seq == SEQ_LAST);
    assign w_ack_ge  = (i_cmd.ack_seq >= r_oldest_seq);
    assign w_ack_dup = (({1'b0, i_cmd.ack_seq} + (SEQ_W + 1)'(1)) == {1'b0, r_oldest_seq});
    assign w_dup_inc = r_dup_acks + 1'b1;

    // one release step: stop the oldest, finish at the acked number or empty window
    assign w_slide_ack = (r_state == ST_IDLE) ? i_cmd.ack_seq : r_ack;
    assign w_stop_last = (r_oldest_seq == w_slide_ack) || (r_outstanding == OUT_W'(1));

    always_comb begin
        n_state        = r_state;
        n_initial_seq  = r_initial_seq;
        n_window_limit = r_window_limit;
        n_oldest_seq   = r_oldest_seq;
        n_next_seq     = r_next_seq;
        n_outstanding  = r_outstanding;
        n_dup_acks     = r_dup_acks;
        n_ack          = r_ack;
        n_out_valid    = r_out_valid && !i_out_ready;
        w_emit         = 1'b0;
        w_emit_item    = '{event_res: EV_NONE, seq: '0, last: 1'b1};

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && w_out_free) begin
                    w_emit = 1'b1;
                    case (i_cmd.kind)
                        CMD_SEND: begin
                            w_emit_item.seq = r_next_seq;
                            if (w_full) begin
                                w_emit_item.event_res = EV_REFUSE;
                            end else begin
                                w_emit_item.event_res = EV_TX;
                                n_next_seq    = r_next_seq + 1'b1;
                                n_outstanding = r_outstanding + 1'b1;
                            end
                        end
                        CMD_ACK: begin
                            if (r_outstanding == '0) begin
                                w_emit_item.event_res = EV_REJECT;
                                w_emit_item.seq       = i_cmd.ack_seq;
                            end else if (w_ack_ge) begin
                                w_emit_item.event_res = EV_STOP;
                                w_emit_item.seq       = r_oldest_seq;
                                w_emit_item.last      = w_stop_last;
                                n_oldest_seq  = r_oldest_seq + 1'b1;
                                n_outstanding = r_outstanding - 1'b1;
                                n_dup_acks    = '0;
                                n_ack         = i_cmd.ack_seq;
                                if (!w_stop_last) begin
                                    n_state = ST_SLIDE;
                                end
                            end else if (w_ack_dup) begin
                                w_emit_item.seq = r_oldest_seq;
                                if (w_dup_inc >= DUP_THRESHOLD) begin
                                    w_emit_item.event_res = EV_RETX;
                                    n_dup_acks = '0;
                                end else begin
                                    w_emit_item.event_res = EV_NONE;
                                    n_dup_acks = w_dup_inc;
                                end
                            end else begin
                                w_emit_item.event_res = EV_REJECT;
                                w_emit_item.seq       = i_cmd.ack_seq;
                            end
                        end
                        CMD_ACK_BAD: begin
                            w_emit_item.event_res = EV_REJECT;
                            w_emit_item.seq       = i_cmd.ack_seq;
                        end
                        CMD_TIMEOUT: begin
                            if (r_outstanding != '0) begin
                                w_emit_item.event_res = EV_RETX;
                                w_emit_item.seq       = r_oldest_seq;
                            end
                        end
                        default: begin
                            w_emit_item.event_res = EV_NONE;
                        end
                    endcase
                end
            end
            ST_SLIDE: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    w_emit_item.event_res = EV_STOP;
                    w_emit_item.seq       = r_oldest_seq;
                    w_emit_item.last      = w_stop_last;
                    n_oldest_seq  = r_oldest_seq + 1'b1;
                    n_outstanding = r_outstanding - 1'b1;
                    if (w_stop_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
        end

        // the user must make register writes only while idle; the block itself does not enforce it
        if (i_cfg_wr.init_we) begin
            n_initial_seq = i_cfg_wr.wdata[SEQ_W-1:0];
            if (r_outstanding == '0) begin
                n_oldest_seq = i_cfg_wr.wdata[SEQ_W-1:0];
                n_next_seq   = i_cfg_wr.wdata[SEQ_W-1:0];
                n_dup_acks   = '0;
            end
        end
        if (i_cfg_wr.limit_we) begin
            n_window_limit = i_cfg_wr.wdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_initial_seq  <= '0;
            r_window_limit <= WINDOW_LIMIT_RESET;
            r_oldest_seq   <= '0;
            r_next_seq     <= '0;
            r_outstanding  <= '0;
            r_dup_acks     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_initial_seq  <= n_initial_seq;
            r_window_limit <= n_window_limit;
            r_oldest_seq   <= n_oldest_seq;
            r_next_seq     <= n_next_seq;
            r_outstanding  <= n_outstanding;
            r_dup_acks     <= n_dup_acks;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ack <= n_ack;
        if (w_emit) begin
            r_out_item <= w_emit_item;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data              = r_out_item;
    assign o_cfg_view.initial_seq  = r_initial_seq;
    assign o_cfg_view.window_limit = r_window_limit;

`ifndef NO_ASSERTIONS
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= OUT_W'(WINDOW_DEPTH))
        else $error("outstanding count past window depth");

    a_span_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_seq - r_oldest_seq) == SEQ_W'(r_outstanding))
        else $error("sequence span disagrees with outstanding count");

    a_slide_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SLIDE) |-> (r_outstanding != '0))
        else $error("release run with empty window");

    a_slide_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_SLIDE && r_state == ST_IDLE) |-> r_out_item.last)
        else $error("release run ended without last");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_sender_fast_retransmit.sv =====
// An accepted input beat is written into the command queue, and its event is then registered
// in the output register; earlier queued work or output stalls delay it further.
// An ack that releases n packets (n up to the window depth) gives n timer-stop events, one
// per cycle while the output is not stalled; no new command is taken until the last one.
// A two-entry command queue keeps taking items while the back end works or stalls.
// Reset: synchronous, active low; window empty, sequence numbers 0, window limit 8.
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// Sender-side window control with cumulative acks and fast retransmit:
// front classifier and queue, back executor, APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_fast_retransmit
    import swsfr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic      w_cmd_valid;
    logic      w_cmd_ready;
    t_cmd      w_cmd;
    t_cfg_wr   w_cfg_wr;
    t_cfg_view w_cfg_view;
    logic      w_wr_beat;

    assign pready    = 1'b1;
    assign w_wr_beat = psel && penable && pwrite && pready;

    assign w_cfg_wr.init_we  = w_wr_beat && (paddr[2] == REG_INITIAL_SEQ);
    assign w_cfg_wr.limit_we = w_wr_beat && (paddr[2] == REG_WINDOW_LIMIT);
    assign w_cfg_wr.wdata    = pwdata;

    always_comb begin
        case (paddr[2])
            REG_INITIAL_SEQ:  prdata = CFG_DATA_W'(w_cfg_view.initial_seq);
            REG_WINDOW_LIMIT: prdata = CFG_DATA_W'(w_cfg_view.window_limit);
            default:          prdata = '0;
        endcase
    end

    swsfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    swsfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_cfg_wr    (w_cfg_wr),
        .o_cfg_view  (w_cfg_view),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_sender_fast_retransmit.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_sender_fast_retransmit
// Self-checking bench for the sliding-window sender. A directed table walks
// the corner cases: empty window, full window, a zero limit, the end of the
// sequence space, bad checksums, stale acks and the duplicate-ack retransmit.
// Random phases follow with different register settings and idle patterns.
// An in-bench window tracker predicts event beats (check rows queue their own
// result); a monitor compares each output beat field by field to the oldest.
// ----------------------------------------------------------------------------
module tb_sliding_window_sender_fast_retransmit;
    timeunit 1ns;
    timeprecision 1ps;

    import swsfr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_INITIAL_SEQ  = {REG_INITIAL_SEQ, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_LIMIT = {REG_WINDOW_LIMIT, 2'b00};
    localparam int MAX_EVENTS      = WINDOW_DEPTH + 1;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int DIR_ROWS        = 24;
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT [PHASES] =
        '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd5, 4'd2};

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_in_item              item;
        t_out_item             res;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sliding_window_sender_fast_retransmit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window tracker
    logic [SEQ_W-1:0]   win_oldest = '0;
    logic [SEQ_W-1:0]   win_next   = '0;
    logic [OUT_W-1:0]   win_count  = '0;
    logic [DUP_W-1:0]   dup_count  = '0;
    logic [LIMIT_W-1:0] win_limit  = WINDOW_LIMIT_RESET;

    t_out_item step_events [MAX_EVENTS];
    int        step_count;
    t_out_item pending_events [$];
    t_out_item want_event;

    int items_sent     = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;
    int full_slides    = 0;
    int dup_retx       = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    t_dir_row directed_rows [DIR_ROWS];

    function automatic void stash_event(t_out_item b);
        pending_events.insert(pending_events.size(), b);
    endfunction

    function automatic t_out_item take_event();
        t_out_item b;
        b = pending_events[0];
        pending_events.delete(0);
        return b;
    endfunction

    function automatic void note_event(logic [2:0] code, logic [SEQ_W-1:0] s);
        step_events[step_count] = '{event_res: code, seq: s, last: 1'b0};
        step_count++;
    endfunction

    function automatic void advance_window(t_in_item it);
        int             eff;
        int             rel;
        int             i;
        logic [SEQ_W:0] span;
        step_count = 0;
        case (it.action)
            ACT_SEND: begin
                eff = (int'(win_limit) < WINDOW_DEPTH) ? int'(win_limit) : WINDOW_DEPTH;
                if (int'(win_count) >= eff || win_next == SEQ_LAST) begin
                    note_event(EV_REFUSE, win_next);
                end else begin
                    note_event(EV_TX, win_next);
                    win_next++;
                    win_count++;
                end
            end
            ACT_ACK: begin
                if (!it.ack_checksum_ok || win_count == 0) begin
                    note_event(EV_REJECT, it.ack_seq);
                end else if (it.ack_seq >= win_oldest) begin
                    span = {1'b0, it.ack_seq} - {1'b0, win_oldest} + 1'b1;
                    rel  = (span < win_count) ? int'(span) : int'(win_count);
                    for (i = 0; i < rel; i++) begin
                        note_event(EV_STOP, win_oldest);
                        win_oldest++;
                    end
                    win_count = win_count - OUT_W'(rel);
                    dup_count = '0;
                    if (rel == WINDOW_DEPTH) full_slides++;
                end else if ({1'b0, it.ack_seq} + 1'b1 == {1'b0, win_oldest}) begin
                    dup_count = dup_count + 1'b1;
                    if (dup_count >= DUP_THRESHOLD) begin
                        note_event(EV_RETX, win_oldest);
                        dup_count = '0;
                        dup_retx++;
                    end else begin
                        note_event(EV_NONE, win_oldest);
                    end
                end else begin
                    note_event(EV_REJECT, it.ack_seq);
                end
            end
            ACT_TIMEOUT: begin
                if (win_count == 0) note_event(EV_NONE, '0);
                else note_event(EV_RETX, win_oldest);
            end
            default: note_event(EV_NONE, '0);
        endcase
        step_events[step_count-1].last = 1'b1;
    endfunction

    function automatic void apply_config(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] data);
        if (addr == ADDR_INITIAL_SEQ) begin
            // only an empty window picks up the new start
            if (win_count == 0) begin
                win_oldest = data[SEQ_W-1:0];
                win_next   = data[SEQ_W-1:0];
                dup_count  = '0;
            end
        end else if (addr == ADDR_WINDOW_LIMIT) begin
            win_limit = data[LIMIT_W-1:0];
        end
    endfunction

    function automatic t_dir_row row_item(logic [1:0] act, logic [SEQ_W-1:0] ack,
                                          logic ok);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.item = '{action: act, ack_seq: ack, ack_checksum_ok: ok};
        return r;
    endfunction

    function automatic t_dir_row row_check(logic [1:0] act, logic [SEQ_W-1:0] ack,
                                           logic ok, logic [2:0] code,
                                           logic [SEQ_W-1:0] s);
        t_dir_row r;
        r      = row_item(act, ack, ok);
        r.kind = ROW_CHECK;
        r.res  = '{event_res: code, seq: s, last: 1'b1};
        return r;
    endfunction

    function automatic t_dir_row row_cfg(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic t_in_item random_item(int send_pct);
        t_in_item it;
        int       pick;
        it.ack_seq         = $urandom;
        it.ack_checksum_ok = 1'($urandom_range(1));
        pick               = $urandom_range(99);
        if (pick < send_pct) begin
            it.action = ACT_SEND;
        end else if (pick < 90) begin
            it.action          = ACT_ACK;
            it.ack_checksum_ok = ($urandom_range(19) != 0);
            case ($urandom_range(9))
                0, 1, 2:    it.ack_seq = win_oldest - 1;
                3, 4, 5, 6: it.ack_seq = win_oldest + $urandom_range(win_count);
                7:          it.ack_seq = SEQ_LAST;
                8:          it.ack_seq = win_oldest - 2 - $urandom_range(5);
                default:    it.ack_seq = $urandom;
            endcase
        end else if (pick < 96) begin
            it.action = ACT_TIMEOUT;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_config(addr, data);
        cfg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, let every pending event come out, then settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_item(input t_in_item it, input logic typed, input t_out_item res);
        int i;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_window(it);
        items_sent++;
        if (typed) begin
            stash_event(res);
        end else begin
            for (i = 0; i < step_count; i++) stash_event(step_events[i]);
        end
    endtask

    task automatic sender_gap();
        int g;
        g = 0;
        while ($urandom_range(99) < send_idle_pct) g++;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d events pending",
                         STALL_LIMIT, pending_events.size());
                $display("status: fail");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected event beat: ev=%0d seq=%h last=%0b",
                                 o_out_data.event_res, o_out_data.seq, o_out_data.last);
                end else begin
                    want_event = take_event();
                    if (o_out_data.event_res !== want_event.event_res ||
                        o_out_data.seq !== want_event.seq ||
                        o_out_data.last !== want_event.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("event beat %0d: expected ev=%0d seq=%h last=%0b,",
                                   results_seen, want_event.event_res, want_event.seq,
                                   want_event.last);
                            $display(" got ev=%0d seq=%h last=%0b",
                                     o_out_data.event_res, o_out_data.seq,
                                     o_out_data.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int               r;
        int               p;
        int               k;
        int               send_pct;
        logic [SEQ_W-1:0] start_seq;

        directed_rows = '{
            row_check(ACT_TIMEOUT, '0, 1'b1, EV_NONE, '0),
            row_check(ACT_ACK, SEQ_LAST, 1'b1, EV_REJECT, SEQ_LAST),
            row_check(ACT_UNUSED, SEQ_LAST, 1'b1, EV_NONE, '0),
            row_cfg(ADDR_WINDOW_LIMIT, 32'd2),
            row_check(ACT_SEND, '0, 1'b0, EV_TX, 32'd0),
            row_check(ACT_SEND, SEQ_LAST, 1'b1, EV_TX, 32'd1),
            row_check(ACT_SEND, '0, 1'b0, EV_REFUSE, 32'd2),
            row_check(ACT_ACK, '0, 1'b0, EV_REJECT, 32'd0),
            row_check(ACT_TIMEOUT, '0, 1'b0, EV_RETX, 32'd0),
            row_item(ACT_ACK, '0, 1'b1),
            row_item(ACT_ACK, '0, 1'b1),
            row_item(ACT_ACK, '0, 1'b1),
            row_item(ACT_ACK, '0, 1'b1),
            row_item(ACT_ACK, SEQ_LAST, 1'b1),
            row_cfg(ADDR_WINDOW_LIMIT, 32'd0),
            row_check(ACT_SEND, '0, 1'b0, EV_REFUSE, 32'd2),
            row_cfg(ADDR_INITIAL_SEQ, SEQ_LAST - 1),
            row_cfg(ADDR_WINDOW_LIMIT, 32'd15),
            row_check(ACT_SEND, '0, 1'b0, EV_TX, SEQ_LAST - 1),
            row_check(ACT_SEND, '0, 1'b0, EV_REFUSE, SEQ_LAST),
            row_item(ACT_ACK, '0, 1'b1),
            row_item(ACT_ACK, SEQ_LAST - 2, 1'b1),
            row_item(ACT_ACK, SEQ_LAST - 1, 1'b1),
            row_cfg(ADDR_INITIAL_SEQ, SEQ_LAST)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    drain_results();
                    cfg_write(directed_rows[r].addr, directed_rows[r].data);
                end
                ROW_CHECK: push_item(directed_rows[r].item, 1'b1, directed_rows[r].res);
                default:   push_item(directed_rows[r].item, 1'b0, '0);
            endcase
        end

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0:       start_seq = '0;
                2:       start_seq = SEQ_LAST - 6;
                5:       start_seq = SEQ_LAST - 3;
                7:       start_seq = 32'h8000_0000;
                default: start_seq = $urandom;
            endcase
            cfg_write(ADDR_WINDOW_LIMIT, CFG_DATA_W'(PHASE_LIMIT[p]));
            cfg_write(ADDR_INITIAL_SEQ, start_seq);
            send_idle_pct  = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 29 : 0;
            recv_stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 29 : 0;
            send_pct       = $urandom_range(60, 30);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // hold off now and then until the block has answered everything
                if ((p == 0 && k == 12) || $urandom_range(29) == 0) drain_results();
                push_item(random_item(send_pct), 1'b0, '0);
                sender_gap();
            end
        end

        drain_results();
        if (pending_events.size() != 0) mismatches += pending_events.size();

        $display("ran %0d items into %0d event beats across %0d register writes",
                 items_sent, results_seen, cfg_writes);
        $display("full-window slides: %0d, fast retransmits on duplicate acks: %0d",
                 full_slides, dup_retx);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sliding_window_sender_fast_retransmit.f =====
rtl/core/swsfr_pkg.sv
rtl/core/swsfr_front.sv
rtl/core/swsfr_back.sv
rtl/core/sliding_window_sender_fast_retransmit.sv
tb/tb_sliding_window_sender_fast_retransmit.sv
